@@ src/double_ended_queue_unit_assert.svh @@
// Assertion macros shared by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on an explicit clock and active-low reset.
`define DQU_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error("assertion failed");
// Check a property on the block clock and reset.
`define DQU_ASSERT(lbl, prop) \
	`DQU_ASSERT_CLK(lbl, clk, arst_n, prop)
`else
`define DQU_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop)
`define DQU_ASSERT(lbl, prop)
`endif

`endif

@@ src/dqu_pkg.sv @@
// Types and constants of the double-ended queue unit.
package dqu_pkg;

	localparam int DEPTH_DEF      = 256;
	localparam int WORD_WIDTH_DEF = 32;

	localparam int ACT_W     = 3;
	localparam int STAT_W    = 2;
	localparam int DATA_W    = 32;
	localparam int POS_W     = 8;
	localparam int FILL_W    = 9;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 112;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_BACK  = 3'd0,
		ACT_PUSH_FRONT = 3'd1,
		ACT_POP_BACK   = 3'd2,
		ACT_POP_FRONT  = 3'd3,
		ACT_READ       = 3'd4
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

endpackage

@@ src/dqu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dqu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ src/double_ended_queue_unit.sv @@
// Double-ended queue unit: bounded deque of words in a ring RAM.
//
// Input stream (s_*): one beat per action. s_tuser carries the action code
// (push back, push front, pop back, pop front, read at position); s_tdata
// carries the word to push and the read position.
// Output stream (m_*): exactly one beat per input beat, in order. m_tuser
// carries the status (ok, empty, full, out of range); m_tdata carries the
// popped or read word, the front and back words after the action and the
// fill count.
// Each beat runs through idle, front, back and done: the action and its
// data read go to the RAM in the accept cycle, then the front and back
// words are read back one per cycle through the single RAM read port; the
// done step loads the output register. No new beat is taken until then.
// The output register is separate, so the next beat is accepted while a
// result still waits. If the receiver stalls, the finished next result
// holds in the last step until the output register frees.
// Reset empties the queue (front pointer and count to zero); RAM contents
// are left as they are and stale entries never reach the output.
module double_ended_queue_unit #(
	parameter int DEPTH      = dqu_pkg::DEPTH_DEF,
	parameter int WORD_WIDTH = dqu_pkg::WORD_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// value[31:0], position[39:32]
	input  logic [dqu_pkg::S_TDATA_W-1:0]  s_tdata,
	// action[2:0]
	input  logic [dqu_pkg::ACT_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// data_word[31:0], front_word[63:32], back_word[95:64], fill_count[104:96], zero pad
	output logic [dqu_pkg::M_TDATA_W-1:0]  m_tdata,
	// status[1:0]
	output logic [dqu_pkg::STAT_W-1:0]     m_tuser
);

	import dqu_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_FRONT,
		SEQ_BACK,
		SEQ_DONE
	} seq_t;

	function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
		input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return PTR_W'(sum);
	endfunction

	seq_t                  state_q;
	logic [PTR_W-1:0]      front_q;
	logic [CNT_W-1:0]      count_q;
	status_t               op_status_q;
	logic                  has_data_q;
	logic [WORD_WIDTH-1:0] data_q;
	logic [WORD_WIDTH-1:0] front_word_q;

	logic                  m_tvalid_q;
	status_t               out_status_q;
	logic [DATA_W-1:0]     out_data_q;
	logic [DATA_W-1:0]     out_front_q;
	logic [DATA_W-1:0]     out_back_q;
	logic [FILL_W-1:0]     out_fill_q;

	logic                  accept;
	logic                  out_free;
	logic [DATA_W-1:0]     in_value;
	logic [POS_W-1:0]      in_position;
	logic [PTR_W-1:0]      back_slot;
	logic                  is_empty;
	logic                  is_full;
	logic                  pos_out;
	logic                  acc_push;
	logic                  acc_pop;

	logic [PTR_W-1:0]      next_front;
	logic [CNT_W-1:0]      next_count;
	status_t               next_status;
	logic                  next_has_data;
	logic [PTR_W-1:0]      acc_rd_addr;

	logic                  ram_wr_en;
	logic [PTR_W-1:0]      ram_wr_addr;
	logic [WORD_WIDTH-1:0] ram_wr_data;
	logic [PTR_W-1:0]      ram_rd_addr;
	logic [WORD_WIDTH-1:0] ram_rd_data;

	assign in_value    = s_tdata[DATA_W-1:0];
	assign in_position = s_tdata[DATA_W +: POS_W];

	assign s_tready = (state_q == SEQ_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign acc_push = accept && (s_tuser == ACT_PUSH_BACK || s_tuser == ACT_PUSH_FRONT);
	assign acc_pop  = accept && (s_tuser == ACT_POP_BACK || s_tuser == ACT_POP_FRONT);

	assign back_slot = ring_add(front_q, CNT_W'(count_q - 1'b1));
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q >= FULL_CNT);
	assign pos_out   = (CMP_W'(in_position) >= CMP_W'(count_q));

	always_comb begin
		next_front    = front_q;
		next_count    = count_q;
		next_status   = STAT_OK;
		next_has_data = 1'b0;
		acc_rd_addr   = front_q;
		ram_wr_en     = 1'b0;
		ram_wr_addr   = ring_add(front_q, count_q);
		unique case (s_tuser)
			ACT_PUSH_BACK: begin
				if (is_full) begin
					next_status = STAT_FULL;
				end else begin
					ram_wr_en  = 1'b1;
					next_count = CNT_W'(count_q + 1'b1);
				end
			end
			ACT_PUSH_FRONT: begin
				if (is_full) begin
					next_status = STAT_FULL;
				end else begin
					next_front  = (front_q == '0) ? LAST_SLOT : PTR_W'(front_q - 1'b1);
					ram_wr_en   = 1'b1;
					ram_wr_addr = next_front;
					next_count  = CNT_W'(count_q + 1'b1);
				end
			end
			ACT_POP_BACK: begin
				acc_rd_addr = back_slot;
				if (is_empty) begin
					next_status = STAT_EMPTY;
				end else begin
					next_has_data = 1'b1;
					next_count    = CNT_W'(count_q - 1'b1);
				end
			end
			ACT_POP_FRONT: begin
				if (is_empty) begin
					next_status = STAT_EMPTY;
				end else begin
					next_has_data = 1'b1;
					next_front    = ring_add(front_q, CNT_W'(1));
					next_count    = CNT_W'(count_q - 1'b1);
				end
			end
			ACT_READ: begin
				acc_rd_addr = ring_add(front_q, CNT_W'(in_position));
				if (is_empty) begin
					next_status = STAT_EMPTY;
				end else if (pos_out) begin
					next_status = STAT_RANGE;
				end else begin
					next_has_data = 1'b1;
				end
			end
			default: begin
			end
		endcase
		ram_wr_en = ram_wr_en && accept;
	end

	assign ram_wr_data = WORD_WIDTH'(in_value);

	always_comb begin
		unique case (state_q)
			SEQ_IDLE:  ram_rd_addr = acc_rd_addr;
			SEQ_FRONT: ram_rd_addr = front_q;
			SEQ_BACK:  ram_rd_addr = back_slot;
			SEQ_DONE:  ram_rd_addr = back_slot;
			default:   ram_rd_addr = back_slot;
		endcase
	end

	dqu_ram #(
		.WIDTH(WORD_WIDTH),
		.DEPTH(1 << PTR_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= SEQ_IDLE;
			front_q      <= '0;
			count_q      <= '0;
			m_tvalid_q   <= 1'b0;
			op_status_q  <= STAT_OK;
			has_data_q   <= 1'b0;
			data_q       <= '0;
			front_word_q <= '0;
			out_status_q <= STAT_OK;
			out_data_q   <= '0;
			out_front_q  <= '0;
			out_back_q   <= '0;
			out_fill_q   <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != SEQ_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				SEQ_IDLE: begin
					if (accept) begin
						front_q     <= next_front;
						count_q     <= next_count;
						op_status_q <= next_status;
						has_data_q  <= next_has_data;
						state_q     <= SEQ_FRONT;
					end
				end
				SEQ_FRONT: begin
					data_q  <= has_data_q ? ram_rd_data : '0;
					state_q <= SEQ_BACK;
				end
				SEQ_BACK: begin
					front_word_q <= ram_rd_data;
					state_q      <= SEQ_DONE;
				end
				SEQ_DONE: begin
					if (out_free) begin
						m_tvalid_q   <= 1'b1;
						out_status_q <= op_status_q;
						out_data_q   <= DATA_W'(data_q);
						out_front_q  <= is_empty ? '0 : DATA_W'(front_word_q);
						out_back_q   <= is_empty ? '0 : DATA_W'(ram_rd_data);
						out_fill_q   <= FILL_W'(count_q);
						state_q      <= SEQ_IDLE;
					end
				end
				default: begin
					state_q <= SEQ_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(M_TDATA_W - 3 * DATA_W - FILL_W){1'b0}}, out_fill_q, out_back_q,
		out_front_q, out_data_q};

`include "double_ended_queue_unit_assert.svh"

	`DQU_ASSERT(a_count_bound, count_q <= FULL_CNT)
	`DQU_ASSERT(a_push_grows, acc_push && !is_full |=> count_q == $past(count_q) + 1'b1)
	`DQU_ASSERT(a_pop_shrinks, acc_pop && !is_empty |=> count_q == $past(count_q) - 1'b1)
	`DQU_ASSERT(a_empty_zero, m_tvalid_q && out_fill_q == '0 |-> out_front_q == '0 && out_back_q == '0)
	`DQU_ASSERT(a_fail_no_data, m_tvalid_q && out_status_q != STAT_OK |-> out_data_q == '0)

endmodule
